[rtl/inverse_mod_power_of_two_defines.svh]
// assertion macros for the checker file
`ifndef INVERSE_MOD_POWER_OF_TWO_DEFINES_SVH
`define INVERSE_MOD_POWER_OF_TWO_DEFINES_SVH

// plain property, sampled on the checker clock, off during reset
`define IMP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("imp assertion failed");

// condition in one cycle implies a consequence in the next
`define IMP_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("imp assertion failed");

`endif

[rtl/imp_pkg.sv]
// shared types and constants for the odd-part inverse block
package imp_pkg;

    localparam int VALUE_W = 32;
    localparam int SHIFT_W = 5;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_NORM = 4'b0010,
        S_INV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic shift_step;
        logic inv_step;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic odd;
        logic last_iter;
    } t_status;

endpackage

[rtl/inverse_mod_power_of_two.sv]
// top level: inverse of the odd part of a word modulo 2^WIDTH
//
// input channel: i_valid / o_ready carry i_value; only its low WIDTH bits count.
// output channel: o_valid / i_ready carry o_inverse, o_shift and o_zero_error.
// the block takes one transaction at a time; o_ready is high only while idle.
// after acceptance the trailing zeros are shifted out one per cycle, then the
// inverse is built one bit per cycle by a shared subtract-and-shift step,
// then the result register is loaded once it has room. a zero input skips
// both loops and flags o_zero_error with inverse and shift at zero.
// the serial normalize and inverse loop sets the rate: the next transaction
// can be taken in the cycle after a result is loaded.
// a stalled receiver holds the result in the output register; a finished item
// waits in the datapath until that register frees; no input is taken meanwhile.
// reset (synchronous, active low) returns the controller to idle and drops
// o_valid; nothing is kept between transactions.
module inverse_mod_power_of_two #(
    parameter int WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [imp_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [imp_pkg::VALUE_W-1:0] o_inverse,
    output logic [imp_pkg::SHIFT_W-1:0] o_shift,
    output logic                        o_zero_error
);

    imp_pkg::t_cmd    w_cmd;
    imp_pkg::t_status w_status;

    imp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    imp_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_value      (i_value),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_inverse    (o_inverse),
        .o_shift      (o_shift),
        .o_zero_error (o_zero_error)
    );

endmodule

[rtl/imp_ctrl.sv]
// controller: sequences normalization, inverse iterations and the result register
module imp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  imp_pkg::t_status i_status,
    output imp_pkg::t_cmd    o_cmd
);

    imp_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_can_pub;

    assign w_can_pub = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            imp_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = imp_pkg::S_NORM;
                end
            end
            imp_pkg::S_NORM: begin
                if (i_status.zero) begin
                    n_state = imp_pkg::S_FIN;
                end else if (i_status.odd) begin
                    n_state = imp_pkg::S_INV;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            imp_pkg::S_INV: begin
                o_cmd.inv_step = 1'b1;
                if (i_status.last_iter) begin
                    n_state = imp_pkg::S_FIN;
                end
            end
            imp_pkg::S_FIN: begin
                // wait for room in the result register
                if (w_can_pub) begin
                    o_cmd.publish = 1'b1;
                    n_state       = imp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = imp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == imp_pkg::S_IDLE);
    assign o_valid = r_out_valid;

endmodule

[rtl/imp_datapath.sv]
// datapath: trailing-zero shifter, bit-serial inverse and result register
module imp_datapath #(
    parameter int WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic [imp_pkg::VALUE_W-1:0] i_value,
    input  imp_pkg::t_cmd               i_cmd,
    output imp_pkg::t_status            o_status,
    output logic [imp_pkg::VALUE_W-1:0] o_inverse,
    output logic [imp_pkg::SHIFT_W-1:0] o_shift,
    output logic                        o_zero_error
);

    localparam int ITER_W = $clog2(WIDTH);

    logic [WIDTH-1:0]            w_b;
    logic [WIDTH-1:0]            r_b, n_b;
    logic [WIDTH-1:0]            r_acc, n_acc;
    logic [WIDTH-1:0]            r_x, n_x;
    logic [WIDTH-1:0]            w_diff;
    logic [imp_pkg::SHIFT_W-1:0] r_cnt, n_cnt;
    logic [ITER_W-1:0]           r_iter, n_iter;
    logic                        r_zero, n_zero;
    logic [imp_pkg::VALUE_W-1:0] w_inv_ext;
    logic [imp_pkg::VALUE_W-1:0] r_inverse;
    logic [imp_pkg::SHIFT_W-1:0] r_shift;
    logic                        r_zero_error;

    // bring the input word to WIDTH bits and the inverse back to the field width
    generate
        if (WIDTH > imp_pkg::VALUE_W) begin : g_wide
            assign w_b       = {{(WIDTH - imp_pkg::VALUE_W){1'b0}}, i_value};
            assign w_inv_ext = r_x[imp_pkg::VALUE_W-1:0];
        end else if (WIDTH == imp_pkg::VALUE_W) begin : g_equal
            assign w_b       = i_value;
            assign w_inv_ext = r_x;
        end else begin : g_narrow
            assign w_b       = i_value[WIDTH-1:0];
            assign w_inv_ext = {{(imp_pkg::VALUE_W - WIDTH){1'b0}}, r_x};
        end
    endgenerate

    // acc holds (1 - odd * x) / 2^i; a set low bit means inverse bit i is one
    assign w_diff = r_acc[0] ? (r_acc - r_b) : r_acc;

    always_comb begin
        n_b    = r_b;
        n_acc  = r_acc;
        n_x    = r_x;
        n_cnt  = r_cnt;
        n_iter = r_iter;
        n_zero = r_zero;
        if (i_cmd.load) begin
            n_b    = w_b;
            n_acc  = {{(WIDTH - 1){1'b0}}, 1'b1};
            n_x    = '0;
            n_cnt  = '0;
            n_iter = '0;
            n_zero = (w_b == '0);
        end else if (i_cmd.shift_step) begin
            n_b   = r_b >> 1;
            n_cnt = r_cnt + 1'b1;
        end else if (i_cmd.inv_step) begin
            n_acc  = w_diff >> 1;
            n_x    = {r_acc[0], r_x[WIDTH-1:1]};
            n_iter = r_iter + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b    <= n_b;
        r_acc  <= n_acc;
        r_x    <= n_x;
        r_cnt  <= n_cnt;
        r_iter <= n_iter;
        r_zero <= n_zero;
        if (i_cmd.publish) begin
            r_inverse    <= r_zero ? '0 : w_inv_ext;
            r_shift      <= r_zero ? '0 : r_cnt;
            r_zero_error <= r_zero;
        end
    end

    assign o_status.zero      = r_zero;
    assign o_status.odd       = r_b[0];
    assign o_status.last_iter = (r_iter == ITER_W'(WIDTH - 1));

    assign o_inverse    = r_inverse;
    assign o_shift      = r_shift;
    assign o_zero_error = r_zero_error;

endmodule

[rtl/imp_checker.sv]
// port-level checker for the odd-part inverse block, with its bind
`include "inverse_mod_power_of_two_defines.svh"

module imp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [imp_pkg::VALUE_W-1:0] inverse,
    input logic [imp_pkg::SHIFT_W-1:0] shift,
    input logic                        zero_error
);

    // a stalled result stays offered and unchanged
    `IMP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `IMP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                     $stable(inverse) && $stable(shift) && $stable(zero_error))
    // one transaction in flight: no second accept right after one
    `IMP_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    // a zero input reports zeros in the result fields
    `IMP_ASSERT(a_zero_fields, !(out_valid && zero_error) || (inverse == '0 && shift == '0))
    // the inverse of an odd number is odd
    `IMP_ASSERT(a_inverse_odd, !(out_valid && !zero_error) || inverse[0])

endmodule

bind inverse_mod_power_of_two imp_checker u_imp_checker (
    .clk        (i_clk),
    .rst_n      (i_rst_n),
    .in_valid   (i_valid),
    .in_ready   (o_ready),
    .out_valid  (o_valid),
    .out_ready  (i_ready),
    .inverse    (o_inverse),
    .shift      (o_shift),
    .zero_error (o_zero_error)
);
